>>> hdl/c2r_pkg.sv
package c2r_pkg;

    // datapath widths
    localparam int XY_W   = 36;   // cordic x/y lanes, room for gain and sign
    localparam int Z_W    = 34;   // cordic angle lane, Q3.28 plus headroom
    localparam int R2_W   = 64;   // squared range, Q32.32
    localparam int DM_W   = 65;   // dot product magnitude
    localparam int SQ_N   = 32;   // square root steps, one result bit each
    localparam int QUO_W  = 31;   // quotient bits below the saturation point
    localparam int ATAN_W = 28;

    localparam logic signed [Z_W-1:0]  PI_Z      = 34'sd843314857;
    localparam logic signed [Z_W-1:0]  HALF_PI_Z = 34'sd421657428;
    localparam logic signed [XY_W-1:0] GAIN_INV  = 36'sd652032874;

    typedef enum logic {
        REG_MODEL_MODE   = 1'b0,
        REG_MIN_RANGE_SQ = 1'b1
    } reg_sel_t;

    // atan(2^-i) in Q3.28, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q28(input int unsigned idx);
        logic [ATAN_W-1:0] a;
        case (idx)
            0:       a = 28'd210828714;
            1:       a = 28'd124459457;
            2:       a = 28'd65760959;
            3:       a = 28'd33381290;
            4:       a = 28'd16755422;
            5:       a = 28'd8385879;
            6:       a = 28'd4193963;
            7:       a = 28'd2097109;
            8:       a = 28'd1048571;
            9:       a = 28'd524287;
            10:      a = 28'd262144;
            11:      a = 28'd131072;
            12:      a = 28'd65536;
            13:      a = 28'd32768;
            14:      a = 28'd16384;
            15:      a = 28'd8192;
            16:      a = 28'd4096;
            17:      a = 28'd2048;
            18:      a = 28'd1024;
            19:      a = 28'd512;
            20:      a = 28'd256;
            21:      a = 28'd128;
            22:      a = 28'd64;
            23:      a = 28'd32;
            24:      a = 28'd16;
            25:      a = 28'd8;
            26:      a = 28'd4;
            27:      a = 28'd2;
            28:      a = 28'd1;
            default: a = 28'd0;
        endcase
        return a;
    endfunction

endpackage

>>> hdl/c2r_in_if.sv
interface c2r_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] speed;
    logic signed [30:0] heading;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, speed, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, speed, heading, output ready);
endinterface

>>> hdl/c2r_out_if.sv
interface c2r_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] range;
    logic signed [30:0] bearing;
    logic signed [31:0] range_rate;
    logic               too_close;

    modport source (output valid, range, bearing, range_rate, too_close, input ready);
    modport sink   (input valid, range, bearing, range_rate, too_close, output ready);
endinterface

>>> hdl/c2r_cordic_cell.sv
module c2r_cordic_cell #(
    parameter int SHIFT     = 0,
    parameter bit VECTORING = 1'b0,
    parameter type side_t   = logic
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [c2r_pkg::XY_W-1:0]  in_x,
    input  logic signed [c2r_pkg::XY_W-1:0]  in_y,
    input  logic signed [c2r_pkg::Z_W-1:0]   in_z,
    input  side_t                            in_side,
    output logic                             out_valid,
    output logic signed [c2r_pkg::XY_W-1:0]  out_x,
    output logic signed [c2r_pkg::XY_W-1:0]  out_y,
    output logic signed [c2r_pkg::Z_W-1:0]   out_z,
    output side_t                            out_side
);
    import c2r_pkg::*;

    logic signed [XY_W-1:0] x_sh, y_sh, x_next, y_next, x_reg, y_reg;
    logic signed [Z_W-1:0]  ang, z_next, z_reg;
    logic                   cw;
    logic                   valid_reg;
    side_t                  side_reg;

    assign x_sh = in_x >>> SHIFT;
    assign y_sh = in_y >>> SHIFT;
    assign ang  = signed'({{(Z_W-ATAN_W){1'b0}}, atan_q28(SHIFT)});

    // vectoring drives y toward zero, rotation drives z toward zero
    assign cw = VECTORING ? ~in_y[XY_W-1] : in_z[Z_W-1];

    always_comb
    begin
        if (cw)
        begin
            x_next = in_x + y_sh;
            y_next = in_y - x_sh;
            z_next = in_z + ang;
        end
        else
        begin
            x_next = in_x - y_sh;
            y_next = in_y + x_sh;
            z_next = in_z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;
endmodule

>>> hdl/c2r_sqrt_cell.sv
module c2r_sqrt_cell #(
    parameter int STEP    = 0,
    parameter type side_t = logic
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [c2r_pkg::R2_W-1:0]  in_rem,
    input  logic [c2r_pkg::R2_W-1:0]  in_res,
    input  side_t                     in_side,
    output logic                      out_valid,
    output logic [c2r_pkg::R2_W-1:0]  out_rem,
    output logic [c2r_pkg::R2_W-1:0]  out_res,
    output side_t                     out_side
);
    import c2r_pkg::*;

    localparam logic [R2_W-1:0] ONE = R2_W'(1) << (R2_W - 2 - 2 * STEP);

    logic [R2_W:0]   trial;
    logic            take;
    logic [R2_W-1:0] rem_next, res_next, rem_reg, res_reg;
    logic            valid_reg;
    side_t           side_reg;

    assign trial = {1'b0, in_res} + {1'b0, ONE};
    assign take  = {1'b0, in_rem} >= trial;

    always_comb
    begin
        if (take)
        begin
            rem_next = in_rem - trial[R2_W-1:0];
            res_next = (in_res >> 1) + ONE;
        end
        else
        begin
            rem_next = in_rem;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_res   = res_reg;
    assign out_side  = side_reg;
endmodule

>>> hdl/c2r_div_cell.sv
module c2r_div_cell #(
    parameter int BIT     = 0,
    parameter type side_t = logic
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [c2r_pkg::R2_W-1:0]   in_rem,
    input  logic [c2r_pkg::QUO_W-1:0]  in_quo,
    input  logic [31:0]                in_den,
    input  side_t                      in_side,
    output logic                       out_valid,
    output logic [c2r_pkg::R2_W-1:0]   out_rem,
    output logic [c2r_pkg::QUO_W-1:0]  out_quo,
    output logic [31:0]                out_den,
    output side_t                      out_side
);
    import c2r_pkg::*;

    logic [R2_W-1:0]  trial, rem_next, rem_reg;
    logic [QUO_W-1:0] quo_next, quo_reg;
    logic [31:0]      den_reg;
    logic             take;
    logic             valid_reg;
    side_t            side_reg;

    assign trial = {{(R2_W-32){1'b0}}, in_den} << BIT;
    assign take  = in_rem >= trial;

    always_comb
    begin
        quo_next      = in_quo;
        quo_next[BIT] = take;
        rem_next      = take ? in_rem - trial : in_rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;
endmodule

>>> hdl/cartesian_to_radar_polar.sv
// throughput: one item per cycle while the pipeline advances; every cell of every chain is a
// pipeline register: two cordic chains, 32 root cells and 31 divide cells
// the pipeline moves whenever its last stage is empty or the output register frees up
// reset: asynchronous, active low; clears valid bits, model_mode to 0, min_range_squared to 7
module cartesian_to_radar_polar #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    c2r_in_if.sink      obj,
    c2r_out_if.source   meas
);
    import c2r_pkg::*;

    // side data carried along each chain
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] sp;
        logic signed [30:0] hd;
        logic               mode;
    } in_t;

    typedef struct packed {
        in_t                d;
        logic [R2_W-1:0]    r2;
        logic               close;
        logic               kill;
    } vs_t;

    typedef struct packed {
        in_t                d;
        logic [R2_W-1:0]    r2;
        logic               close;
        logic               kill;
        logic signed [30:0] brg;
        logic               neg;
    } rs_t;

    typedef struct packed {
        logic [DM_W-1:0]    dmag;
        logic               dneg;
        logic               close;
        logic               kill;
        logic signed [30:0] brg;
    } qs_t;

    typedef struct packed {
        logic               dneg;
        logic               ovf;
        logic               close;
        logic               kill;
        logic signed [30:0] brg;
    } ds_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] mag34(input logic signed [33:0] v);
        return v[33] ? 33'(-v) : 33'(v);
    endfunction

    // ---------------- configuration registers ----------------
    logic        mode_reg;
    logic [15:0] min_r2_reg;
    reg_sel_t    sel;

    assign sel    = reg_sel_t'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            min_r2_reg <= 16'd7;
        end
        else if (psel && penable && pwrite)
        begin
            case (sel)
                REG_MODEL_MODE:   mode_reg   <= pwdata[0];
                REG_MIN_RANGE_SQ: min_r2_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_MODEL_MODE:   prdata = {31'd0, mode_reg};
            REG_MIN_RANGE_SQ: prdata = {16'd0, min_r2_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    logic advance;      // whole pipeline shifts one stage
    logic last_valid;
    logic out_valid_reg;
    logic out_load;

    assign out_load  = !out_valid_reg || meas.ready;
    assign advance   = !last_valid || out_load;
    assign obj.ready = advance;

    // ---------------- input register ----------------
    logic v0_reg;
    in_t  s0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= obj.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg.px   <= obj.pos_x;
            s0_reg.py   <= obj.pos_y;
            s0_reg.vx   <= obj.vel_x;
            s0_reg.vy   <= obj.vel_y;
            s0_reg.sp   <= obj.speed;
            s0_reg.hd   <= obj.heading;
            s0_reg.mode <= mode_reg;
        end
    end

    // ---------------- squared range ----------------
    logic            v1_reg, v2_reg;
    in_t             s1_reg;
    logic [R2_W-1:0] sqx_reg, sqy_reg;
    vs_t             s2_reg;
    logic [R2_W-1:0] r2_sum;

    assign r2_sum = sqx_reg + sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg       <= s0_reg;
            sqx_reg      <= 64'(mag32(s0_reg.px)) * 64'(mag32(s0_reg.px));
            sqy_reg      <= 64'(mag32(s0_reg.py)) * 64'(mag32(s0_reg.py));
            s2_reg.d     <= s1_reg;
            s2_reg.r2    <= r2_sum;
            // threshold is min_range_squared moved from Q16.16 to Q32.32
            s2_reg.close <= r2_sum < {32'd0, min_r2_reg, 16'd0};
            s2_reg.kill  <= (r2_sum < {32'd0, min_r2_reg, 16'd0}) || (r2_sum == '0);
        end
    end

    // ---------------- bearing: vectoring cordic chain ----------------
    logic                   vec_v [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] vec_x [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] vec_y [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  vec_z [CORDIC_STAGES+1];
    vs_t                    vec_s [CORDIC_STAGES+1];

    // left half plane starts from the mirrored point at plus or minus pi
    always_comb
    begin
        vec_v[0] = v2_reg;
        vec_s[0] = s2_reg;
        if (s2_reg.d.px[31])
        begin
            vec_x[0] = -XY_W'(s2_reg.d.px);
            vec_y[0] = -XY_W'(s2_reg.d.py);
            vec_z[0] = s2_reg.d.py[31] ? -PI_Z : PI_Z;
        end
        else
        begin
            vec_x[0] = XY_W'(s2_reg.d.px);
            vec_y[0] = XY_W'(s2_reg.d.py);
            vec_z[0] = '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_vec
        c2r_cordic_cell #(
            .SHIFT     (i),
            .VECTORING (1'b1),
            .side_t    (vs_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (vec_v[i]),
            .in_x      (vec_x[i]),
            .in_y      (vec_y[i]),
            .in_z      (vec_z[i]),
            .in_side   (vec_s[i]),
            .out_valid (vec_v[i+1]),
            .out_x     (vec_x[i+1]),
            .out_y     (vec_y[i+1]),
            .out_z     (vec_z[i+1]),
            .out_side  (vec_s[i+1])
        );
    end

    // ---------------- heading: rotation cordic chain ----------------
    logic                   rot_v [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] rot_x [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] rot_y [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  rot_z [CORDIC_STAGES+1];
    rs_t                    rot_s [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  brg_z, hd_z;

    assign brg_z = vec_z[CORDIC_STAGES];
    assign hd_z  = Z_W'(vec_s[CORDIC_STAGES].d.hd);

    always_comb
    begin
        rot_v[0]       = vec_v[CORDIC_STAGES];
        rot_s[0].d     = vec_s[CORDIC_STAGES].d;
        rot_s[0].r2    = vec_s[CORDIC_STAGES].r2;
        rot_s[0].close = vec_s[CORDIC_STAGES].close;
        rot_s[0].kill  = vec_s[CORDIC_STAGES].kill;
        // clamp the accumulated angle to plus or minus pi
        if (brg_z > PI_Z)
            rot_s[0].brg = 31'(PI_Z);
        else if (brg_z < -PI_Z)
            rot_s[0].brg = 31'(-PI_Z);
        else
            rot_s[0].brg = 31'(brg_z);
        rot_x[0] = GAIN_INV;
        rot_y[0] = '0;
        // headings past a quarter turn rotate by the angle a half turn away and negate
        if (hd_z > HALF_PI_Z)
        begin
            rot_z[0]     = hd_z - PI_Z;
            rot_s[0].neg = 1'b1;
        end
        else if (hd_z < -HALF_PI_Z)
        begin
            rot_z[0]     = hd_z + PI_Z;
            rot_s[0].neg = 1'b1;
        end
        else
        begin
            rot_z[0]     = hd_z;
            rot_s[0].neg = 1'b0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        c2r_cordic_cell #(
            .SHIFT     (i),
            .VECTORING (1'b0),
            .side_t    (rs_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (rot_v[i]),
            .in_x      (rot_x[i]),
            .in_y      (rot_y[i]),
            .in_z      (rot_z[i]),
            .in_side   (rot_s[i]),
            .out_valid (rot_v[i+1]),
            .out_x     (rot_x[i+1]),
            .out_y     (rot_y[i+1]),
            .out_z     (rot_z[i+1]),
            .out_side  (rot_s[i+1])
        );
    end

    // ---------------- velocity, dot product terms, dot product ----------------
    rs_t                    rs_end;
    logic signed [XY_W-1:0] cos_w, sin_w;
    logic signed [67:0]     pc_w, ps_w;

    assign rs_end = rot_s[CORDIC_STAGES];
    assign cos_w  = rs_end.neg ? -rot_x[CORDIC_STAGES] : rot_x[CORDIC_STAGES];
    assign sin_w  = rs_end.neg ? -rot_y[CORDIC_STAGES] : rot_y[CORDIC_STAGES];
    assign pc_w   = rs_end.d.sp * cos_w;
    assign ps_w   = rs_end.d.sp * sin_w;

    logic               vm_v_reg, dp_v_reg, ds_v_reg;
    logic signed [31:0] vm_px_reg, vm_py_reg;
    logic signed [33:0] vm_vx_reg, vm_vy_reg;
    qs_t                vm_s_reg, dp_s_reg, ds_s_reg;
    logic [R2_W-1:0]    vm_r2_reg, dp_r2_reg, ds_r2_reg;
    logic [R2_W-1:0]    m1_reg, m2_reg;
    logic               n1_reg, n2_reg;
    logic               p1n, p2n;
    logic [DM_W-1:0]    dmag_w;
    logic               dneg_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_v_reg <= 1'b0;
            dp_v_reg <= 1'b0;
            ds_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            vm_v_reg <= rot_v[CORDIC_STAGES];
            dp_v_reg <= vm_v_reg;
            ds_v_reg <= dp_v_reg;
        end
    end

    // terms that are zero count as positive
    assign p1n = n1_reg && (m1_reg != '0);
    assign p2n = n2_reg && (m2_reg != '0);

    always_comb
    begin
        if (p1n == p2n)
        begin
            dmag_w = {1'b0, m1_reg} + {1'b0, m2_reg};
            dneg_w = p1n;
        end
        else if (m1_reg >= m2_reg)
        begin
            dmag_w = {1'b0, m1_reg - m2_reg};
            dneg_w = p1n;
        end
        else
        begin
            dmag_w = {1'b0, m2_reg - m1_reg};
            dneg_w = p2n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // velocity stage: mode 1 uses speed times cos and sin, floored by 2^30
            vm_px_reg      <= rs_end.d.px;
            vm_py_reg      <= rs_end.d.py;
            vm_vx_reg      <= rs_end.d.mode ? pc_w[63:30] : 34'(rs_end.d.vx);
            vm_vy_reg      <= rs_end.d.mode ? ps_w[63:30] : 34'(rs_end.d.vy);
            vm_r2_reg      <= rs_end.r2;
            vm_s_reg.dmag  <= '0;
            vm_s_reg.dneg  <= 1'b0;
            vm_s_reg.close <= rs_end.close;
            vm_s_reg.kill  <= rs_end.kill;
            vm_s_reg.brg   <= rs_end.brg;
            // product stage: magnitudes and signs of px*vx and py*vy
            m1_reg         <= 64'(mag32(vm_px_reg)) * 64'(mag34(vm_vx_reg));
            m2_reg         <= 64'(mag32(vm_py_reg)) * 64'(mag34(vm_vy_reg));
            n1_reg         <= vm_px_reg[31] ^ vm_vx_reg[33];
            n2_reg         <= vm_py_reg[31] ^ vm_vy_reg[33];
            dp_r2_reg      <= vm_r2_reg;
            dp_s_reg       <= vm_s_reg;
            // sum stage: signed dot product as sign and magnitude
            ds_r2_reg      <= dp_r2_reg;
            ds_s_reg.dmag  <= dmag_w;
            ds_s_reg.dneg  <= dneg_w;
            ds_s_reg.close <= dp_s_reg.close;
            ds_s_reg.kill  <= dp_s_reg.kill;
            ds_s_reg.brg   <= dp_s_reg.brg;
        end
    end

    // ---------------- range: square root chain ----------------
    logic            sq_v   [SQ_N+1];
    logic [R2_W-1:0] sq_rem [SQ_N+1];
    logic [R2_W-1:0] sq_res [SQ_N+1];
    qs_t             sq_s   [SQ_N+1];

    assign sq_v[0]   = ds_v_reg;
    assign sq_rem[0] = ds_r2_reg;
    assign sq_res[0] = '0;
    assign sq_s[0]   = ds_s_reg;

    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        c2r_sqrt_cell #(
            .STEP   (i),
            .side_t (qs_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (sq_v[i]),
            .in_rem    (sq_rem[i]),
            .in_res    (sq_res[i]),
            .in_side   (sq_s[i]),
            .out_valid (sq_v[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_res   (sq_res[i+1]),
            .out_side  (sq_s[i+1])
        );
    end

    // ---------------- range rate: saturation check and divide chain ----------------
    logic            ov_v_reg;
    logic [R2_W-1:0] ov_rem_reg;
    logic [31:0]     ov_den_reg;
    ds_t             ov_s_reg;
    logic [31:0]     rng_w;
    qs_t             sq_end;

    assign rng_w  = sq_res[SQ_N][31:0];
    assign sq_end = sq_s[SQ_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_v_reg <= 1'b0;
        else if (advance)
            ov_v_reg <= sq_v[SQ_N];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ov_rem_reg     <= sq_end.dmag[R2_W-1:0];
            ov_den_reg     <= rng_w;
            // quotient of 2^31 or more saturates either way
            ov_s_reg.ovf   <= sq_end.dmag >= ({{(DM_W-32){1'b0}}, rng_w} << QUO_W);
            ov_s_reg.dneg  <= sq_end.dneg;
            ov_s_reg.close <= sq_end.close;
            ov_s_reg.kill  <= sq_end.kill;
            ov_s_reg.brg   <= sq_end.brg;
        end
    end

    logic             dv_v   [QUO_W+1];
    logic [R2_W-1:0]  dv_rem [QUO_W+1];
    logic [QUO_W-1:0] dv_quo [QUO_W+1];
    logic [31:0]      dv_den [QUO_W+1];
    ds_t              dv_s   [QUO_W+1];

    assign dv_v[0]   = ov_v_reg;
    assign dv_rem[0] = ov_rem_reg;
    assign dv_quo[0] = '0;
    assign dv_den[0] = ov_den_reg;
    assign dv_s[0]   = ov_s_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        c2r_div_cell #(
            .BIT    (QUO_W - 1 - i),
            .side_t (ds_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (dv_v[i]),
            .in_rem    (dv_rem[i]),
            .in_quo    (dv_quo[i]),
            .in_den    (dv_den[i]),
            .in_side   (dv_s[i]),
            .out_valid (dv_v[i+1]),
            .out_rem   (dv_rem[i+1]),
            .out_quo   (dv_quo[i+1]),
            .out_den   (dv_den[i+1]),
            .out_side  (dv_s[i+1])
        );
    end

    // ---------------- output register ----------------
    ds_t                dv_end;
    logic signed [31:0] rate_w;
    logic        [31:0] out_range_reg;
    logic signed [30:0] out_brg_reg;
    logic signed [31:0] out_rate_reg;
    logic               out_close_reg;

    assign last_valid = dv_v[QUO_W];
    assign dv_end     = dv_s[QUO_W];

    always_comb
    begin
        if (dv_end.dneg)
            rate_w = dv_end.ovf ? 32'sh8000_0000 : -signed'({1'b0, dv_quo[QUO_W]});
        else
            rate_w = dv_end.ovf ? 32'sh7fff_ffff : signed'({1'b0, dv_quo[QUO_W]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= last_valid;
    end

    // too close and origin both give zeros
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_range_reg <= dv_end.kill ? '0 : dv_den[QUO_W];
            out_brg_reg   <= dv_end.kill ? '0 : dv_end.brg;
            out_rate_reg  <= dv_end.kill ? '0 : rate_w;
            out_close_reg <= dv_end.close;
        end
    end

    assign meas.valid      = out_valid_reg;
    assign meas.range      = out_range_reg;
    assign meas.bearing    = out_brg_reg;
    assign meas.range_rate = out_rate_reg;
    assign meas.too_close  = out_close_reg;

`ifndef SYNTH
    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_close_reg |->
            out_range_reg == '0 && out_brg_reg == '0 && out_rate_reg == '0)
        else $error("too close result carries nonzero fields");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> advance)
        else $error("pipeline stalled with empty output register");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_brg_reg <= 31'sd843314857 && out_brg_reg >= -31'sd843314857)
        else $error("bearing outside plus or minus pi");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_range_reg == '0 |-> out_rate_reg == '0 && out_brg_reg == '0)
        else $error("zero range with nonzero bearing or rate");
`endif
endmodule
